// ----- hw/rtl/blake2_hash_engine_top_assert.svh -----
// Assertion macros for the BLAKE2 hash engine checker
`ifndef BLAKE2_HASH_ENGINE_TOP_ASSERT_SVH
`define BLAKE2_HASH_ENGINE_TOP_ASSERT_SVH
// Implication checked every clock, off during reset
`define B2_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked every clock, off during reset
`define B2_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- hw/rtl/b2_pkg.sv -----
// Shared constants, tables and G-function helpers for the BLAKE2 engine
package b2_pkg;
  localparam int unsigned CNT_W = 64;

  localparam logic [63:0] IV [8] = '{
    64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B,
    64'h3C6EF372FE94F82B, 64'hA54FF53A5F1D36F1,
    64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
    64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179};

  localparam logic [63:0] PARAM_S = 64'h0000_0000_0101_0020;
  localparam logic [63:0] PARAM_B = 64'h0000_0000_0101_0040;

  localparam logic [3:0] SIGMA [10][16] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
    '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
      4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
    '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
      4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
    '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
      4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
    '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
      4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
    '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
      4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
    '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
      4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
    '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
      4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
    '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
      4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
    '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
      4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}};

  // G-function column/diagonal indexes for each of the eight calls
  localparam logic [3:0] GA [8] = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd0, 4'd1, 4'd2, 4'd3};
  localparam logic [3:0] GB [8] = '{4'd4, 4'd5, 4'd6, 4'd7, 4'd5, 4'd6, 4'd7, 4'd4};
  localparam logic [3:0] GC [8] = '{4'd8, 4'd9, 4'd10, 4'd11, 4'd10, 4'd11, 4'd8, 4'd9};
  localparam logic [3:0] GD [8] = '{4'd12, 4'd13, 4'd14, 4'd15, 4'd15, 4'd12, 4'd13, 4'd14};

  // Starting chain entry for a variant
  function automatic logic [63:0] init_h(input logic big, input logic [2:0] i);
    logic [63:0] h;
    h = big ? IV[i] : {32'h0, IV[i][63:32]};
    if (i == 3'd0) h = h ^ (big ? PARAM_B : PARAM_S);
    return h;
  endfunction

  // Right rotate by a fixed amount in the selected word size
  function automatic logic [63:0] rotr(input logic [63:0] x, input logic big,
                                       input logic [5:0] nb, input logic [4:0] ns);
    logic [31:0] s;
    s = (x[31:0] >> ns) | (x[31:0] << (6'd32 - {1'b0, ns}));
    return big ? ((x >> nb) | (x << (7'd64 - {1'b0, nb}))) : {32'h0, s};
  endfunction

  typedef struct packed {
    logic        start;
    logic        final_blk;
    logic        big;
    logic [63:0] counter;
  } cmp_ctl_t;
endpackage

// ----- hw/rtl/b2_gunit.sv -----
// Shared G function datapath: one half of a G call per cycle
module b2_gunit
  import b2_pkg::*;
(
  input  logic        big,
  input  logic        second,
  input  logic [63:0] va,
  input  logic [63:0] vb,
  input  logic [63:0] vc,
  input  logic [63:0] vd,
  input  logic [63:0] m,
  output logic [63:0] na,
  output logic [63:0] nb,
  output logic [63:0] nc,
  output logic [63:0] nd
);
  logic [63:0] mask;
  logic [63:0] a1, d1, c1, b1;
  always_comb begin
    mask = big ? '1 : 64'h0000_0000_FFFF_FFFF;
    a1 = (va + vb + m) & mask;
    d1 = rotr(vd ^ a1, big, second ? 6'd16 : 6'd32, second ? 5'd8 : 5'd16);
    c1 = (vc + d1) & mask;
    b1 = rotr(vb ^ c1, big, second ? 6'd63 : 6'd24, second ? 5'd7 : 5'd12);
    na = a1;
    nd = d1;
    nc = c1;
    nb = b1;
  end
endmodule

// ----- hw/rtl/b2_compress.sv -----
// Compression sequencer: runs the shared G unit over all rounds
module b2_compress
  import b2_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  cmp_ctl_t      ctl,
  input  logic [63:0]   h_in [8],
  input  logic [63:0]   blk [16],
  output logic [63:0]   h_out [8],
  output logic          done
);
  logic [63:0] v_r [16];
  logic [63:0] v_nxt [16];
  logic        busy_r, busy_nxt;
  logic        big_r, big_nxt;
  logic [3:0]  round_r, round_nxt;
  logic [3:0]  g_r, g_nxt;
  logic [3:0]  sig_row;
  logic [3:0]  midx;
  logic [63:0] mw;
  logic [63:0] na, nb, nc, nd;
  logic [63:0] mask;

  // Round number modulo ten picks the permutation row
  assign sig_row = (round_r >= 4'd10) ? round_r - 4'd10 : round_r;
  assign midx = SIGMA[sig_row][{g_r[3:1], 1'b0} | {3'b0, g_r[0]}];
  assign mw = big_r ? blk[midx] : (midx[0] ? {32'h0, blk[midx[3:1]][63:32]}
                                           : {32'h0, blk[midx[3:1]][31:0]});
  assign mask = big_r ? '1 : 64'h0000_0000_FFFF_FFFF;

  b2_gunit u_g (
    .big(big_r), .second(g_r[0]),
    .va(v_r[GA[g_r[3:1]]]), .vb(v_r[GB[g_r[3:1]]]),
    .vc(v_r[GC[g_r[3:1]]]), .vd(v_r[GD[g_r[3:1]]]),
    .m(mw), .na(na), .nb(nb), .nc(nc), .nd(nd));

  always_comb begin
    v_nxt = v_r;
    busy_nxt = busy_r;
    big_nxt = big_r;
    round_nxt = round_r;
    g_nxt = g_r;
    done = 1'b0;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      big_nxt = ctl.big;
      round_nxt = '0;
      g_nxt = '0;
      for (int i = 0; i < 8; i++) begin
        v_nxt[i] = h_in[i] & (ctl.big ? '1 : 64'h0000_0000_FFFF_FFFF);
        v_nxt[i + 8] = ctl.big ? IV[i] : {32'h0, IV[i][63:32]};
      end
      if (ctl.big) v_nxt[12] = v_nxt[12] ^ ctl.counter;
      else begin
        v_nxt[12] = v_nxt[12] ^ {32'h0, ctl.counter[31:0]};
        v_nxt[13] = v_nxt[13] ^ {32'h0, ctl.counter[63:32]};
      end
      if (ctl.final_blk)
        v_nxt[14] = v_nxt[14] ^ (ctl.big ? '1 : 64'h0000_0000_FFFF_FFFF);
    end else if (busy_r) begin
      v_nxt[GA[g_r[3:1]]] = na;
      v_nxt[GB[g_r[3:1]]] = nb;
      v_nxt[GC[g_r[3:1]]] = nc;
      v_nxt[GD[g_r[3:1]]] = nd;
      g_nxt = g_r + 4'd1;
      if (g_r == 4'd15) begin
        round_nxt = round_r + 4'd1;
        if (round_r == (big_r ? 4'd11 : 4'd9)) begin
          busy_nxt = 1'b0;
          done = 1'b1;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++)
      h_out[i] = (h_in[i] ^ v_nxt[i] ^ v_nxt[i + 8]) & mask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      round_r <= '0;
      g_r <= '0;
      big_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      round_r <= round_nxt;
      g_r <= g_nxt;
      big_r <= big_nxt;
    end
    v_r <= v_nxt;
  end
endmodule

// ----- hw/rtl/blake2_hash_engine_top.sv -----
// BLAKE2s-256 / BLAKE2b-512 hash engine top level
//  channel | dir | handshake        | payload
//  in_     | in  | tvalid/tready    | tdata: message_word, byte_count; tuser: end_of_message
//  out_    | out | tvalid/tready    | tdata: digest_word; tlast: last_word
//  cfg_    | in  | we               | wdata: variant
// A word: an accept in S_IDLE, then one byte per cycle in S_PACK, then a closing step.
// A byte that lands on a full block first waits for a start and a compression of
// 16 half-G steps per round on one shared G unit, during which packing stalls.
// A final word then zeroes the tail one byte a cycle, compresses and makes 4 or 8 transfers.
// Reset is synchronous; input is held off until all digest words are taken.
module blake2_hash_engine_top
  import b2_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // [63:0] message_word, [67:64] byte_count, rest zero
  input  logic        in_tuser,   // [0] end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] digest_word
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);
  localparam logic [2:0] S_IDLE = 3'd0, S_PACK = 3'd1, S_CMP = 3'd2,
                         S_FIN = 3'd3, S_OUT = 3'd4;

  logic [2:0]  st_r, st_nxt;
  logic        big_r;
  logic [63:0] h_r [8];
  logic [63:0] h_c [8];
  logic [63:0] blk_r [16];
  logic [7:0]  fill_r, fill_nxt;
  logic [63:0] cnt_r, cnt_nxt;
  logic [63:0] word_r;
  logic [3:0]  left_r, left_nxt;
  logic [2:0]  bi_r, bi_nxt;
  logic        eom_r;
  logic        fin_r, fin_nxt;
  logic [2:0]  oi_r, oi_nxt;
  logic        cdone;
  cmp_ctl_t    ctl;
  logic [7:0]  blk_bytes;
  logic        in_acc, out_acc;
  logic [3:0]  cnt_in;

  assign blk_bytes = big_r ? 8'd128 : 8'd64;
  assign in_tready = (st_r == S_IDLE) && rst_n;
  assign in_acc = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;
  assign cnt_in = (in_tdata[67:64] > 4'd8) ? 4'd8 : in_tdata[67:64];

  b2_compress u_cmp (.clk(clk), .rst_n(rst_n), .ctl(ctl), .h_in(h_r), .blk(blk_r),
                     .h_out(h_c), .done(cdone));

  always_comb begin
    st_nxt = st_r;
    fill_nxt = fill_r;
    cnt_nxt = cnt_r;
    left_nxt = left_r;
    bi_nxt = bi_r;
    fin_nxt = fin_r;
    oi_nxt = oi_r;
    ctl = '{start: 1'b0, final_blk: fin_r, big: big_r, counter: cnt_r};
    case (st_r)
      S_IDLE: if (in_acc) begin
        left_nxt = cnt_in;
        bi_nxt = '0;
        st_nxt = S_PACK;
      end
      S_PACK: begin
        // one byte per cycle unless the block is full; compress a full block only when more data follows
        if (left_r == 4'd0) begin
          if (eom_r) begin
            st_nxt = S_FIN;
            fin_nxt = 1'b1;
            cnt_nxt = cnt_r + {56'h0, fill_r};
          end else st_nxt = S_IDLE;
        end else if (fill_r >= blk_bytes) begin
          cnt_nxt = cnt_r + {56'h0, blk_bytes};
          fin_nxt = 1'b0;
          ctl.start = 1'b1;
          ctl.final_blk = 1'b0;
          ctl.counter = cnt_nxt;
          st_nxt = S_CMP;
        end else begin
          fill_nxt = fill_r + 8'd1;
          left_nxt = left_r - 4'd1;
          bi_nxt = bi_r + 3'd1;
        end
      end
      S_FIN: begin
        // zero the tail one byte a cycle, then start the final compression
        if (fill_r >= blk_bytes) begin
          ctl.start = 1'b1;
          st_nxt = S_CMP;
        end else fill_nxt = fill_r + 8'd1;
      end
      S_CMP: if (cdone) begin
        fill_nxt = fin_r ? fill_r : 8'd0;
        oi_nxt = '0;
        st_nxt = fin_r ? S_OUT : S_PACK;
      end
      S_OUT: if (out_acc) begin
        oi_nxt = oi_r + 3'd1;
        if (out_tlast) begin
          st_nxt = S_IDLE;
          fill_nxt = '0;
          cnt_nxt = '0;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  assign out_tvalid = (st_r == S_OUT);
  assign out_tlast = big_r ? (oi_r == 3'd7) : (oi_r == 3'd3);
  assign out_tdata = big_r ? h_r[oi_r] :
                     {h_r[{oi_r[1:0], 1'b1}][31:0], h_r[{oi_r[1:0], 1'b0}][31:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      big_r <= 1'b0;
      fill_r <= '0;
      cnt_r <= '0;
      fin_r <= 1'b0;
      oi_r <= '0;
      left_r <= '0;
      bi_r <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= init_h(1'b0, 3'(i));
    end else if (cfg_we) begin
      big_r <= cfg_wdata;
      fill_r <= '0;
      cnt_r <= '0;
      st_r <= S_IDLE;
      for (int i = 0; i < 8; i++) h_r[i] <= init_h(cfg_wdata, 3'(i));
    end else begin
      st_r <= st_nxt;
      fill_r <= fill_nxt;
      cnt_r <= cnt_nxt;
      fin_r <= fin_nxt;
      oi_r <= oi_nxt;
      left_r <= left_nxt;
      bi_r <= bi_nxt;
      if (st_r == S_CMP && cdone) h_r <= h_c;
      if (st_r == S_OUT && out_acc && out_tlast)
        for (int i = 0; i < 8; i++) h_r[i] <= init_h(big_r, 3'(i));
    end
  end

  // payload: input word capture and byte packing into the block buffer
  always_ff @(posedge clk) begin
    if (in_acc) begin
      word_r <= in_tdata[63:0];
      eom_r <= in_tuser;
    end
    if (st_r == S_PACK && left_r != 4'd0 && fill_r < blk_bytes)
      blk_r[fill_r[6:3]][{fill_r[2:0], 3'b000} +: 8] <= word_r[{bi_r, 3'b000} +: 8];
    if (st_r == S_FIN && fill_r < blk_bytes)
      blk_r[fill_r[6:3]][{fill_r[2:0], 3'b000} +: 8] <= 8'h00;
  end
endmodule

// ----- hw/rtl/blake2_hash_engine_chk.sv -----
// Port-level checker for the BLAKE2 hash engine, bound to the top level
`include "blake2_hash_engine_top_assert.svh"
module blake2_hash_engine_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        out_tlast
);
  `B2_ASSERT_IMP(a_no_overlap, out_tvalid, !in_tready)
  `B2_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `B2_ASSERT_NXT(a_accept_busy, in_tvalid && in_tready, !in_tready)
  `B2_ASSERT_NXT(a_last_done, out_tvalid && out_tready && out_tlast, !out_tvalid)
endmodule

bind blake2_hash_engine_top blake2_hash_engine_chk u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tlast(out_tlast));
